@@ rtl/core/bdq_pkg.sv @@
// Shared command, status and cell control definitions for the bounded deque.
package bdq_pkg;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CONTAINS   = 3'd4,
        CMD_REMOVE     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic remove;
    } cell_ctrl_t;

endpackage

@@ rtl/core/bdq_if.sv @@
// Request and response channel interfaces for the bounded deque.
interface bdq_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        cmd;
    logic signed [31:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic [4:0]         held_count;
    logic               is_empty;
    logic               found;
    logic [1:0]         status;

    modport source (output valid, output front_value, output back_value, output held_count,
                    output is_empty, output found, output status, input ready);
    modport sink   (input valid, input front_value, input back_value, input held_count,
                    input is_empty, input found, input status, output ready);
endinterface

@@ rtl/core/bdq_cell.sv @@
// One deque storage cell: holds an entry, compares it, and shifts with its neighbors.
module bdq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CW         = 5,
    parameter int IDX        = 0
) (
    input  logic                  clk,
    input  bdq_pkg::cell_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [CW-1:0]         count,
    input  logic [DATA_WIDTH-1:0] left_data,
    input  logic [DATA_WIDTH-1:0] right_data,
    input  logic                  seen_in,
    output logic                  seen_out,
    output logic [DATA_WIDTH-1:0] data
);
    import bdq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  occupied;
    logic                  match;

    assign occupied = CW'(IDX) < count;
    assign match    = occupied && (data_reg == value);
    assign seen_out = seen_in || match;
    assign data     = data_reg;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.push_front)
        begin
            data_next = left_data;
        end
        else if (ctrl.push_back)
        begin
            if (count == CW'(IDX))
            begin
                data_next = value;
            end
        end
        else if (ctrl.pop_front)
        begin
            data_next = right_data;
        end
        else if (ctrl.remove && seen_out)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

@@ rtl/core/bounded_deque_with_search.sv @@
// Top level of the bounded double-ended queue with value search.
// Latency: the response is valid in the cycle after the request transaction.
// Throughput: one transaction per cycle; a new request is taken as the response is taken.
// The first-match priority chain through the cell row sets the cycle time of a remove.
// Reset clears the entry count and response valid; entry storage is not reset.
module bounded_deque_with_search #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);
    import bdq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  found_reg;
    logic                  found_next;
    status_t               status_reg;
    status_t               status_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    cell_ctrl_t            ctrl;
    logic [DATA_WIDTH-1:0] value_w;
    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DATA_WIDTH-1:0] back_sel  [DEPTH];
    logic [DEPTH:0]        seen;
    logic [DATA_WIDTH-1:0] back_data;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = count_reg == CW'(DEPTH);
    assign empty     = count_reg == '0;
    assign value_w   = DATA_WIDTH'($unsigned(req.value));
    assign seen[0]   = 1'b0;

    always_comb
    begin
        ctrl = '0;
        if (accept)
        begin
            case (req.cmd)
                CMD_PUSH_FRONT: ctrl.push_front = !full;
                CMD_PUSH_BACK:  ctrl.push_back  = !full;
                CMD_POP_FRONT:  ctrl.pop_front  = !empty;
                CMD_REMOVE:     ctrl.remove     = 1'b1;
                default:        ctrl = '0;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            bdq_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CW         (CW),
                .IDX        (gi)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .value      (value_w),
                .count      (count_reg),
                .left_data  ((gi == 0) ? value_w : cell_data[(gi == 0) ? 0 : gi - 1]),
                .right_data (cell_data[(gi == DEPTH - 1) ? gi : gi + 1]),
                .seen_in    (seen[gi]),
                .seen_out   (seen[gi + 1]),
                .data       (cell_data[gi])
            );

            assign back_sel[gi] = (count_reg == CW'(gi + 1)) ? cell_data[gi] : '0;
        end
    endgenerate

    always_comb
    begin
        back_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_data = back_data | back_sel[i];
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next = 1'b1;
            found_next     = 1'b0;
            status_next    = STAT_DONE;
            case (req.cmd)
                CMD_PUSH_FRONT, CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
                CMD_CONTAINS:
                begin
                    found_next = seen[DEPTH];
                    if (!seen[DEPTH])
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                end
                CMD_REMOVE:
                begin
                    found_next = seen[DEPTH];
                    if (seen[DEPTH])
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                end
                default:
                begin
                    status_next = STAT_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        status_reg <= status_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.front_value = empty ? '0 : 32'(cell_data[0]);
    assign rsp.back_value  = empty ? '0 : 32'(back_data);
    assign rsp.held_count  = 5'(count_reg);
    assign rsp.is_empty    = empty;
    assign rsp.found       = found_reg;
    assign rsp.status      = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_full_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && (req.cmd == CMD_PUSH_FRONT || req.cmd == CMD_PUSH_BACK))
        |=> (count_reg == CW'(DEPTH)) && (status_reg == STAT_FULL))
        else $error("push on full deque changed the count");

    a_pop_front_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !empty && req.cmd == CMD_POP_FRONT)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("pop front did not decrement the count");

    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted transaction produced no response");

endmodule
